### src/hde_pkg.sv
// ----------------------------------------------------------------------------
// hde_pkg
// Shared constants and pattern tables for the html entity decoder.
// ----------------------------------------------------------------------------
package hde_pkg;

  // default character width
  localparam int CHAR_BITS_DEF = 16;

  // entity set and buffer sizes
  localparam int NUM_ENT  = 6;
  localparam int HOLD_MAX = 5;
  localparam int WORK_MAX = 6;
  localparam int CNT_BITS = 3;
  localparam int CFG_IDX_BITS = 3;

  // upper-case range and fold offset
  localparam int CH_UPPER_A = 8'h41;
  localparam int CH_UPPER_Z = 8'h5a;
  localparam int CASE_OFFSET = 32;

  // entity order: nbsp, quot, lt, gt, amp, shy
  localparam logic [CNT_BITS-1:0] ENT_LEN [NUM_ENT] = '{
    3'd6, 3'd6, 3'd4, 3'd4, 3'd5, 3'd5
  };

  // pattern text, lower case, zero past the end
  localparam logic [7:0] ENT_TEXT [NUM_ENT][WORK_MAX] = '{
    '{8'h26, 8'h6e, 8'h62, 8'h73, 8'h70, 8'h3b},
    '{8'h26, 8'h71, 8'h75, 8'h6f, 8'h74, 8'h3b},
    '{8'h26, 8'h6c, 8'h74, 8'h3b, 8'h00, 8'h00},
    '{8'h26, 8'h67, 8'h74, 8'h3b, 8'h00, 8'h00},
    '{8'h26, 8'h61, 8'h6d, 8'h70, 8'h3b, 8'h00},
    '{8'h26, 8'h73, 8'h68, 8'h79, 8'h3b, 8'h00}
  };

  // replacement codes after reset
  localparam int CODE_RESET [NUM_ENT] = '{32, 34, 60, 62, 38, 173};

endpackage

### src/html_entity_decoder.sv
// ----------------------------------------------------------------------------
// html_entity_decoder
// Streaming decoder that replaces &nbsp; &quot; &lt; &gt; &amp; &shy; by
// configurable single characters, letters matched without regard to case.
// ----------------------------------------------------------------------------
// An item is taken while the sequencer is idle, then it works through a
// six-entry character queue with one shared compare unit that checks the head
// character against one column of all six patterns. Queued characters are
// scanned in turn; a mismatch releases the held '&' and pushes each other held
// character back to the queue front, and at end of text the held characters
// are flushed in order. The sequencer stalls while a result cannot be placed
// in the output register.
// in_ready is high only while the sequencer is idle. The output register lets
// a new item enter while the last result of the previous one is still waiting.
module html_entity_decoder
  import hde_pkg::*;
#(
  parameter int CHAR_BITS = CHAR_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CHAR_BITS-1:0]    cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [CHAR_BITS-1:0]    text_char,
  input  logic                    end_of_text,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [CHAR_BITS-1:0]    out_char,
  output logic                    out_last
);

  // sequencer states
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_UNWIND = 2'd2;
  localparam logic [1:0] ST_FLUSH  = 2'd3;

  localparam logic [NUM_ENT-1:0] ALL_ENT = '1;

  typedef logic [CHAR_BITS-1:0] char_t;

  // registers
  logic [1:0]          state, state_next;
  char_t               code [NUM_ENT];
  char_t               pend [HOLD_MAX];
  char_t               pend_next [HOLD_MAX];
  logic [CNT_BITS-1:0] pc, pc_next;
  logic [NUM_ENT-1:0]  alive, alive_next;
  char_t               que [WORK_MAX];
  char_t               que_next [WORK_MAX];
  logic [CNT_BITS-1:0] qn, qn_next;
  logic                eot, eot_next;

  // compare unit and emission control
  char_t               head_fold;
  logic [NUM_ENT-1:0]  match, full, pre;
  char_t               full_code;
  logic                can_emit;
  logic                do_emit;
  char_t               emit_char;
  logic                emit_last;
  logic                pop;

  assign in_ready = (state == ST_IDLE);
  assign can_emit = !out_valid || out_ready;

  // shared compare: head character against one pattern column
  always_comb begin
    head_fold = que[0];
    if (que[0] >= CHAR_BITS'(CH_UPPER_A) && que[0] <= CHAR_BITS'(CH_UPPER_Z)) begin
      head_fold = que[0] + CHAR_BITS'(CASE_OFFSET);
    end
    full_code = '0;
    for (int e = 0; e < NUM_ENT; e++) begin
      match[e] = alive[e] && (head_fold == CHAR_BITS'(ENT_TEXT[e][pc]));
      full[e]  = match[e] && (ENT_LEN[e] == pc + 3'd1);
      pre[e]   = match[e] && (ENT_LEN[e] > pc + 3'd1);
      if (full[e]) begin
        full_code = full_code | code[e];
      end
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    pend_next  = pend;
    pc_next    = pc;
    alive_next = alive;
    que_next   = que;
    qn_next    = qn;
    eot_next   = eot;
    do_emit    = 1'b0;
    emit_char  = que[0];
    emit_last  = 1'b0;
    pop        = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          que_next[0] = text_char;
          qn_next     = 3'd1;
          eot_next    = end_of_text;
          state_next  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (|full) begin
          // complete entity
          if (can_emit) begin
            do_emit    = 1'b1;
            emit_char  = full_code;
            pop        = 1'b1;
            pc_next    = '0;
            alive_next = ALL_ENT;
          end
        end else if ((|pre) && (pc < CNT_BITS'(HOLD_MAX))) begin
          // still a prefix: hold the character
          pend_next[pc] = que[0];
          pc_next       = pc + 3'd1;
          alive_next    = pre;
          pop           = 1'b1;
        end else if (pc == '0) begin
          // plain character
          if (can_emit) begin
            do_emit = 1'b1;
            pop     = 1'b1;
          end
        end else begin
          // mismatch: release the held '&', rescan the rest
          if (can_emit) begin
            do_emit   = 1'b1;
            emit_char = pend[0];
            if (pc >= 3'd2) begin
              state_next = ST_UNWIND;
            end else begin
              pc_next    = '0;
              alive_next = ALL_ENT;
            end
          end
        end
        // pop the head character; when the queue drains, leave the scan
        if (pop) begin
          for (int i = 0; i < WORK_MAX - 1; i++) begin
            que_next[i] = que[i+1];
          end
          qn_next = qn - 3'd1;
          if (qn == 3'd1) begin
            if (eot && pc_next != '0) begin
              state_next = ST_FLUSH;
            end else begin
              state_next = ST_IDLE;
            end
            emit_last = eot && (pc_next == '0);
          end
        end
      end
      ST_UNWIND: begin
        // push the newest held character back to the queue front
        que_next[0] = pend[pc - 3'd1];
        for (int i = 1; i < WORK_MAX; i++) begin
          que_next[i] = que[i-1];
        end
        qn_next = qn + 3'd1;
        pc_next = pc - 3'd1;
        if (pc == 3'd2) begin
          pc_next    = '0;
          alive_next = ALL_ENT;
          state_next = ST_SCAN;
        end
      end
      ST_FLUSH: begin
        // end of text: release held characters in order
        if (can_emit) begin
          do_emit   = 1'b1;
          emit_char = pend[0];
          emit_last = (pc == 3'd1);
          for (int i = 0; i < HOLD_MAX - 1; i++) begin
            pend_next[i] = pend[i+1];
          end
          pc_next = pc - 3'd1;
          if (pc == 3'd1) begin
            alive_next = ALL_ENT;
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pc    <= '0;
      qn    <= '0;
      alive <= ALL_ENT;
      eot   <= 1'b0;
    end else begin
      state <= state_next;
      pc    <= pc_next;
      qn    <= qn_next;
      alive <= alive_next;
      eot   <= eot_next;
    end
  end

  // character buffers
  always_ff @(posedge clk) begin
    pend <= pend_next;
    que  <= que_next;
  end

  // replacement code registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int e = 0; e < NUM_ENT; e++) begin
        code[e] <= CHAR_BITS'(CODE_RESET[e]);
      end
    end else if (cfg_wr_en && (cfg_index < CFG_IDX_BITS'(NUM_ENT))) begin
      code[cfg_index] <= cfg_data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_emit) begin
      out_char <= emit_char;
      out_last <= emit_last;
    end
  end

`ifndef SYNTHESIS
  // held count stays within the hold buffer
  assert property (@(posedge clk) disable iff (rst) pc <= CNT_BITS'(HOLD_MAX))
    else $error("held count above limit");

  // held and queued characters never exceed the work buffer
  assert property (@(posedge clk) disable iff (rst)
    ({1'b0, pc} + {1'b0, qn}) <= 4'(WORK_MAX))
    else $error("work buffer overflow");

  // no item accepted while the queue still holds characters
  assert property (@(posedge clk) disable iff (rst) in_ready |-> (qn == '0))
    else $error("queue not empty while idle");

  // flush only runs with something held
  assert property (@(posedge clk) disable iff (rst) (state == ST_FLUSH) |-> (pc != '0))
    else $error("flush with nothing held");

  // the final result of a text leaves the sequencer idle and empty
  assert property (@(posedge clk) disable iff (rst)
    (do_emit && emit_last) |=> (state == ST_IDLE && pc == '0))
    else $error("last result with work left");
`endif

endmodule

### verif/tb_html_entity_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_html_entity_decoder
// Streams characters into the entity decoder under random idling on both
// sides, predicts the decoded characters with a cycle-free software copy of
// the decode rules and compares every output item in order.
// ----------------------------------------------------------------------------
module tb_html_entity_decoder
  import hde_pkg::*;
();

  localparam int CW            = CHAR_BITS_DEF;
  localparam int MAX_HELD      = 5;
  localparam int MAX_WORK      = 6;
  localparam int NO_MATCH      = -1;
  localparam int CASE_GAP      = 32;
  localparam int EOT_PCT       = 6;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 250000;
  localparam int MAX_REPORTS   = 10;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_NBSP, REG_QUOT, REG_LT, REG_GT, REG_AMP, REG_SHY, REG_SPARE6, REG_SPARE7
  } reg_idx_e;

  typedef enum int {CODES_ZERO, CODES_ONES, CODES_RANDOM} code_fill_e;

  typedef struct packed {
    logic [CW-1:0] ch;
    logic          last;
  } dec_char_t;

  // decode rules, held characters and the decoded characters still owed
  class decoded_text_check;
    logic [CW-1:0] code_of [NUM_ENT];
    logic [CW-1:0] held [MAX_HELD];
    int            held_n;
    string         pat [NUM_ENT];
    logic [CW-1:0] step_out [$];
    dec_char_t     expected_chars [$];
    int            errors;

    function new();
      code_of = '{16'd32, 16'd34, 16'd60, 16'd62, 16'd38, 16'd173};
      pat     = '{"&nbsp;", "&quot;", "&lt;", "&gt;", "&amp;", "&shy;"};
      held_n  = 0;
      errors  = 0;
    endfunction

    function logic [CW-1:0] pat_char(int e, int k);
      return {{(CW-8){1'b0}}, pat[e][k]};
    endfunction

    function void set_code(reg_idx_e idx, logic [CW-1:0] v);
      if (idx <= REG_SHY) begin
        code_of[int'(idx)] = v;
      end
    endfunction

    function int outstanding();
      return expected_chars.size();
    endfunction

    // only plain ascii capitals are folded
    function logic [CW-1:0] fold_case(logic [CW-1:0] c);
      if (c >= "A" && c <= "Z") begin
        return c + CW'(CASE_GAP);
      end
      return c;
    endfunction

    function void emit(logic [CW-1:0] c);
      if (step_out.size() < MAX_WORK) begin
        step_out.push_back(c);
      end
    endfunction

    // held characters plus x: proper prefix of some entity, or a full match
    function bit match_entity(logic [CW-1:0] x, output int full);
      logic [CW-1:0] cand [MAX_WORK];
      int            len;
      bit            is_prefix;
      bit            same;
      full      = NO_MATCH;
      is_prefix = 1'b0;
      len       = held_n + 1;
      for (int k = 0; k < held_n; k++) begin
        cand[k] = fold_case(held[k]);
      end
      cand[held_n] = fold_case(x);
      for (int e = 0; e < NUM_ENT; e++) begin
        if (pat[e].len() >= len) begin
          same = 1'b1;
          for (int k = 0; k < len; k++) begin
            if (cand[k] != pat_char(e, k)) begin
              same = 1'b0;
            end
          end
          if (same && pat[e].len() == len) begin
            full = e;
          end else if (same) begin
            is_prefix = 1'b1;
          end
        end
      end
      return is_prefix;
    endfunction

    // accepted input item: work out the decoded characters it releases
    function void take_char(logic [CW-1:0] c, bit eot);
      logic [CW-1:0] work [MAX_WORK];
      logic [CW-1:0] redo [MAX_WORK];
      logic [CW-1:0] x;
      int            head;
      int            fill;
      int            n_redo;
      int            full;
      bit            is_prefix;
      dec_char_t     item;
      step_out.delete();
      head = 0;
      fill = 0;
      for (int k = 0; k < held_n && fill < MAX_WORK - 1; k++) begin
        work[fill] = held[k];
        fill++;
      end
      work[fill] = c;
      fill++;
      held_n = 0;
      while (head < fill) begin
        x = work[head];
        head++;
        is_prefix = match_entity(x, full);
        if (full != NO_MATCH) begin
          emit(code_of[full]);
          held_n = 0;
        end else if (is_prefix && held_n < MAX_HELD) begin
          held[held_n] = x;
          held_n++;
        end else if (held_n == 0) begin
          emit(x);
        end else begin
          // leading '&' goes out as text, the rest is scanned again
          emit(held[0]);
          n_redo = 0;
          for (int k = 1; k < held_n && n_redo < MAX_WORK; k++) begin
            redo[n_redo] = held[k];
            n_redo++;
          end
          if (n_redo < MAX_WORK) begin
            redo[n_redo] = x;
            n_redo++;
          end
          while (head < fill && n_redo < MAX_WORK) begin
            redo[n_redo] = work[head];
            n_redo++;
            head++;
          end
          work   = redo;
          head   = 0;
          fill   = n_redo;
          held_n = 0;
        end
      end
      // end of text flushes whatever is still held
      if (eot) begin
        for (int k = 0; k < held_n; k++) begin
          emit(held[k]);
        end
        held_n = 0;
      end
      foreach (step_out[i]) begin
        item.ch   = step_out[i];
        item.last = eot && (i == step_out.size() - 1);
        expected_chars.push_back(item);
      end
    endfunction

    // accepted output item against the oldest decoded character owed
    function void check_char(logic [CW-1:0] ch, logic last);
      dec_char_t want;
      if (expected_chars.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("unexpected output item: char %h last %b", ch, last);
        end
      end else begin
        want = expected_chars.pop_front();
        if (want.ch !== ch || want.last !== last) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("output item mismatch: expected char %h last %b, got char %h last %b",
                     want.ch, want.last, ch, last);
          end
        end
      end
    endfunction
  endclass

  logic                    clk;
  logic                    rst;
  logic                    cfg_wr_en;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [CW-1:0]           cfg_data;
  logic                    in_valid;
  logic                    in_ready;
  logic [CW-1:0]           text_char;
  logic                    end_of_text;
  logic                    out_valid;
  logic                    out_ready;
  logic [CW-1:0]           out_char;
  logic                    out_last;

  decoded_text_check sb;
  int                send_idle_pct;
  int                recv_idle_pct;
  int                items_sent;
  int                cycle_count;
  bit                hold_request;
  bit                hold_done;

  html_entity_decoder dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .text_char   (text_char),
    .end_of_text (end_of_text),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_char    (out_char),
    .out_last    (out_last)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever begin
      #5 clk = ~clk;
    end
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_html_entity_decoder failed");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off when asked
  initial begin
    out_ready = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // output items are checked at the rising edge
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        sb.check_char(out_char, out_last);
      end
    end
  end

  // one input item, with a random gap in front; called at a falling edge
  task automatic send_char(input logic [CW-1:0] c, input bit eot);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    text_char   <= c;
    end_of_text <= eot;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    sb.take_char(c, eot);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s, input bit eot_at_end);
    for (int k = 0; k < s.len(); k++) begin
      send_char({{(CW-8){1'b0}}, s[k]}, eot_at_end && (k == s.len() - 1));
    end
  endtask

  function automatic bit pick_eot();
    return $urandom_range(99) < EOT_PCT;
  endfunction

  // stray characters: printable text, '&', entity letters, wide values
  function automatic logic [CW-1:0] noise_char();
    int e;
    int k;
    e = $urandom_range(NUM_ENT - 1);
    k = $urandom_range(sb.pat[e].len() - 1);
    case ($urandom_range(4))
      0: return CW'($urandom_range(16'h7e, 16'h20));
      1: return sb.pat_char(e, 0);
      2: return sb.pat_char(e, k);
      3: return sb.pat_char(e, k) | (CW'($urandom_range(255, 1)) << 8);
      default: return CW'($urandom);
    endcase
  endfunction

  // mostly entities in mixed case, some cut short, the rest noise
  task automatic send_word();
    int            kind;
    int            e;
    int            cut;
    logic [CW-1:0] c;
    kind = $urandom_range(99);
    if (kind < 65) begin
      e   = $urandom_range(NUM_ENT - 1);
      cut = (kind < 45) ? sb.pat[e].len() : $urandom_range(sb.pat[e].len() - 1, 1);
      for (int k = 0; k < cut; k++) begin
        c = sb.pat_char(e, k);
        if (c >= "a" && c <= "z" && $urandom_range(1) == 1) begin
          c = c - CW'(CASE_GAP);
        end
        send_char(c, pick_eot());
      end
      if (cut < sb.pat[e].len()) begin
        send_char(noise_char(), pick_eot());
      end
    end else if (kind < 88) begin
      repeat ($urandom_range(3, 1)) send_char(noise_char(), pick_eot());
    end else begin
      send_char(CW'($urandom), pick_eot());
    end
  endtask

  task automatic send_random(input int n);
    int target;
    target = items_sent + n;
    while (items_sent < target) begin
      send_word();
    end
  endtask

  // wait for every owed item, then let the sequencer settle
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [CW-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    sb.set_code(idx, v);
    @(negedge clk);
  endtask

  task automatic load_codes(input code_fill_e fill);
    logic [CW-1:0] v;
    for (int r = 0; r < NUM_ENT; r++) begin
      case (fill)
        CODES_ZERO: v = '0;
        CODES_ONES: v = '1;
        default:    v = CW'($urandom);
      endcase
      write_reg(reg_idx_e'(r), v);
    end
    // out-of-range indexes must be ignored
    write_reg(REG_SPARE6, CW'($urandom));
    write_reg(REG_SPARE7, CW'($urandom));
    cfg_wr_en <= 1'b0;
  endtask

  // main sequence
  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    text_char     = '0;
    end_of_text   = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_index     = REG_NBSP;
    cfg_data      = '0;
    hold_request  = 1'b0;
    items_sent    = 0;
    send_idle_pct = 8;
    recv_idle_pct = 52;
    sb            = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed text with the reset codes
    send_text("&&quot;", 1'b0);
    send_text("&lT;", 1'b0);
    send_text("&aMp;", 1'b0);
    send_text("&shy;", 1'b1);
    send_text("&nbsP", 1'b1);
    send_char('1, 1'b0);
    send_char('0, 1'b1);
    drain();

    load_codes(CODES_ZERO);
    send_random(125);
    drain();

    // sender now the slow side
    send_idle_pct = 52;
    recv_idle_pct = 8;
    load_codes(CODES_ONES);
    send_random(125);
    drain();

    // no idling; a long receiver hold-off backs the block up
    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_codes(CODES_RANDOM);
    send_random(20);
    hold_request = 1'b1;
    send_random(110);
    drain();

    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("tb_html_entity_decoder passed");
    end else begin
      $display("tb_html_entity_decoder failed");
    end
    $finish;
  end

endmodule

### html_entity_decoder.f
src/hde_pkg.sv
src/html_entity_decoder.sv
verif/tb_html_entity_decoder.sv
